/* src/mru_pkg.sv */
// Shared types and constants for the bounded most-recently-used list.
// Used by mru_cell, bounded_mru_list and mru_checker; no dependencies.
`timescale 1ns / 1ps
`default_nettype none

package mru_pkg;

  localparam int DEPTH    = 16;
  localparam int KEY_BITS = 64;
  localparam int CNT_W    = $clog2(DEPTH + 1);

  localparam int OP_W      = 2;
  localparam int KEY_W     = 64;
  localparam int COUNT_W   = 5;
  localparam int LIMIT_W   = 5;
  localparam logic [LIMIT_W-1:0] LIMIT_RESET = LIMIT_W'(10);

  typedef enum logic [OP_W-1:0] {
    OP_INSERT = 2'd0,
    OP_CHECK  = 2'd1,
    OP_CLEAR  = 2'd2,
    OP_NOP    = 2'd3
  } mru_op_t;

  typedef logic [KEY_BITS-1:0] mru_key_t;

  // Per-beat command broadcast to every cell.
  typedef struct packed {
    logic ins_hit;    // insert of a key already held: rotate front part
    logic ins_new;    // insert of a new key, list grows
    logic ins_evict;  // insert of a new key, oldest drops out
    logic clr;        // empty the list
  } mru_cmd_t;

endpackage

`default_nettype wire

/* src/mru_cell.sv */
// One position of the MRU list: key register, valid flag and comparator.
// Depends on mru_pkg; instantiated in a chain by bounded_mru_list.
`timescale 1ns / 1ps
`default_nettype none

module mru_cell (
  input  wire               clk,
  input  wire               rst,
  input  mru_pkg::mru_cmd_t cmd,
  input  mru_pkg::mru_key_t new_key,
  input  mru_pkg::mru_key_t prev_key,
  input  wire               prev_valid,
  input  wire               next_valid,
  input  wire               prefix_in,
  output mru_pkg::mru_key_t key_q,
  output logic              valid,
  output logic              prefix_out,
  output mru_pkg::mru_key_t tail_key
);
  import mru_pkg::*;

  logic match;
  logic shift;

  assign match      = valid && (key_q == new_key);
  assign prefix_out = prefix_in | match;

  // Hit: cells up to and including the hit take their neighbor's key.
  // Evict: every held cell shifts, the last one's key falls off the end.
  assign shift = cmd.ins_new || (cmd.ins_evict && valid) || (cmd.ins_hit && !prefix_in);

  // Only the oldest held cell reports its key for eviction.
  assign tail_key = (valid && !next_valid) ? key_q : '0;

  always_ff @(posedge clk) begin
    if (rst) begin
      valid <= 1'b0;
    end else if (cmd.clr) begin
      valid <= 1'b0;
    end else if (cmd.ins_new) begin
      valid <= prev_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (shift) begin
      key_q <= prev_key;
    end
  end

endmodule

`default_nettype wire

/* src/bounded_mru_list.sv */
// Top level of the bounded most-recently-used list: cell chain, count and result register.
// Depends on mru_pkg and mru_cell.
//
// The block takes one command beat per clock cycle: start with busy low accepts
// operation and key. The result appears in the next cycle on found,
// evicted, evicted_key and entry_count, marked by done for that one cycle;
// there is no way to hold it, so it must be taken then. Every cell compares
// its key against the incoming one and the affected cells shift in the same
// cycle, so back-to-back beats are fine. busy is high during reset and for the
// first cycle after it. max_entries may only be written while no beat is in
// flight; issue a clear after changing it.
`timescale 1ns / 1ps
`default_nettype none

module bounded_mru_list (
  input  wire                         clk,
  input  wire                         rst,
  input  wire                         start,
  output logic                        busy,
  input  wire  [mru_pkg::OP_W-1:0]    operation,
  input  wire  [mru_pkg::KEY_W-1:0]   key,
  input  wire                         cfg_we,
  input  wire  [mru_pkg::LIMIT_W-1:0] cfg_data,
  output logic                        done,
  output logic                        found,
  output logic                        evicted,
  output logic [mru_pkg::KEY_W-1:0]   evicted_key,
  output logic [mru_pkg::COUNT_W-1:0] entry_count
);
  import mru_pkg::*;

  logic [LIMIT_W-1:0] max_entries;
  logic [CNT_W-1:0]   held_count;
  logic [CNT_W-1:0]   held_count_next;
  logic [CNT_W-1:0]   limit;

  mru_key_t in_key;
  mru_op_t  op;
  logic     accept;
  logic     hit;
  logic     full;
  mru_cmd_t cmd;

  mru_key_t cell_key   [DEPTH];
  mru_key_t tail_key   [DEPTH];
  logic     cell_valid [DEPTH];
  logic     prefix     [DEPTH+1];
  mru_key_t ev_key;

  assign in_key = key[KEY_BITS-1:0];
  assign op     = mru_op_t'(operation);
  assign accept = start && !busy;

  always_comb begin
    if (max_entries == '0) begin
      limit = CNT_W'(1);
    end else if (max_entries > DEPTH) begin
      limit = CNT_W'(DEPTH);
    end else begin
      limit = CNT_W'(max_entries);
    end
  end

  assign prefix[0] = 1'b0;
  assign hit       = prefix[DEPTH];
  assign full      = held_count >= limit;

  always_comb begin
    cmd = '0;
    if (accept) begin
      unique case (op)
        OP_INSERT: begin
          cmd.ins_hit   = hit;
          cmd.ins_new   = !hit && !full;
          cmd.ins_evict = !hit && full;
        end
        OP_CLEAR: cmd.clr = 1'b1;
        default: cmd = '0;
      endcase
    end
  end

  for (genvar i = 0; i < DEPTH; i++) begin : g_cell
    mru_key_t prev_key;
    logic     prev_valid;
    logic     next_valid;

    if (i == 0) begin : g_head
      assign prev_key   = in_key;
      assign prev_valid = 1'b1;
    end else begin : g_body
      assign prev_key   = cell_key[i-1];
      assign prev_valid = cell_valid[i-1];
    end

    if (i == DEPTH - 1) begin : g_end
      assign next_valid = 1'b0;
    end else begin : g_mid
      assign next_valid = cell_valid[i+1];
    end

    mru_cell u_cell (
      .clk        (clk),
      .rst        (rst),
      .cmd        (cmd),
      .new_key    (in_key),
      .prev_key   (prev_key),
      .prev_valid (prev_valid),
      .next_valid (next_valid),
      .prefix_in  (prefix[i]),
      .key_q      (cell_key[i]),
      .valid      (cell_valid[i]),
      .prefix_out (prefix[i+1]),
      .tail_key   (tail_key[i])
    );
  end

  always_comb begin
    ev_key = '0;
    for (int i = 0; i < DEPTH; i++) begin
      ev_key = ev_key | tail_key[i];
    end
  end

  always_comb begin
    held_count_next = held_count;
    if (cmd.clr) begin
      held_count_next = '0;
    end else if (cmd.ins_new) begin
      held_count_next = held_count + CNT_W'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      max_entries <= LIMIT_RESET;
    end else if (cfg_we) begin
      max_entries <= cfg_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy       <= 1'b1;
      done       <= 1'b0;
      held_count <= '0;
    end else begin
      busy       <= 1'b0;
      done       <= accept;
      held_count <= held_count_next;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      found       <= hit && (op == OP_INSERT || op == OP_CHECK);
      evicted     <= cmd.ins_evict;
      evicted_key <= cmd.ins_evict ? KEY_W'(ev_key) : '0;
      entry_count <= COUNT_W'(held_count_next);
    end
  end

endmodule

`default_nettype wire

/* src/mru_checker.sv */
// Port-level checks for bounded_mru_list, attached by bind.
// Depends on mru_pkg and on the bounded_mru_list port list.
`timescale 1ns / 1ps
`default_nettype none

module mru_checker (
  input wire                         clk,
  input wire                         rst,
  input wire                         start,
  input wire                         busy,
  input wire                         done,
  input wire                         found,
  input wire                         evicted,
  input wire  [mru_pkg::KEY_W-1:0]   evicted_key,
  input wire  [mru_pkg::COUNT_W-1:0] entry_count
);
  import mru_pkg::*;

  // Every accepted beat gives exactly one result, in the cycle after it.
  a_result_follows: assert property (@(posedge clk) disable iff (rst)
    (start && !busy) |=> done)
    else $error("accepted beat produced no result");

  a_no_spurious: assert property (@(posedge clk) disable iff (rst)
    !(start && !busy) |=> !done)
    else $error("result without accepted beat");

  a_evict_key_zero: assert property (@(posedge clk) disable iff (rst)
    (done && !evicted) |-> (evicted_key == '0))
    else $error("evicted_key nonzero without eviction");

  a_evict_nonempty: assert property (@(posedge clk) disable iff (rst)
    (done && evicted) |-> (entry_count != '0 && !found))
    else $error("eviction reported on empty list or on a hit");

  a_count_range: assert property (@(posedge clk) disable iff (rst)
    done |-> (entry_count <= DEPTH))
    else $error("entry_count beyond depth");

endmodule

bind bounded_mru_list mru_checker u_mru_checker (.*);

`default_nettype wire

/* bench/tb.sv */
// Self-checking bench for bounded_mru_list: directed and random command beats with a
// scoreboard that keeps its own move-to-front list. Depends on mru_pkg and the RTL.
`timescale 1ns / 1ps

module tb;
  import mru_pkg::*;

  localparam int CYCLE_LIMIT = 200000;

  typedef struct packed {
    logic               found;
    logic               evicted;
    logic [KEY_W-1:0]   dropped;
    logic [COUNT_W-1:0] count;
  } mru_result_t;

  class mru_scoreboard;
    mru_key_t           list_keys [DEPTH];
    int                 held;
    logic [LIMIT_W-1:0] limit;
    mru_result_t        expected_q [$];
    int                 errors;

    function new();
      held   = 0;
      limit  = LIMIT_RESET;
      errors = 0;
    endfunction

    function int pending();
      return expected_q.size();
    endfunction

    // slots 0..n-1 move down one, k goes to the front
    function void move_to_front(int n, mru_key_t k);
      for (int i = n; i > 0; i--) list_keys[i] = list_keys[i-1];
      list_keys[0] = k;
    endfunction

    function void note_beat(mru_op_t op, logic [KEY_W-1:0] raw);
      mru_key_t    k;
      mru_result_t r;
      int          pos;
      int          cap;
      bit          hit;
      k   = mru_key_t'(raw);
      r   = '0;
      hit = 0;
      pos = 0;
      cap = int'(limit);
      if (cap < 1) cap = 1;
      if (cap > DEPTH) cap = DEPTH;
      for (int i = 0; i < held; i++) begin
        if (!hit && list_keys[i] == k) begin
          hit = 1;
          pos = i;
        end
      end
      case (op)
        OP_INSERT: begin
          r.found = hit;
          if (hit) begin
            move_to_front(pos, k);
          end else if (held + 1 > cap) begin
            // count may sit above a lowered limit; it then stays put
            r.evicted = 1'b1;
            r.dropped = KEY_W'(list_keys[held-1]);
            move_to_front(held - 1, k);
          end else begin
            move_to_front(held, k);
            held++;
          end
        end
        OP_CHECK: r.found = hit;
        OP_CLEAR: held = 0;
        default: ;
      endcase
      r.count = COUNT_W'(held);
      expected_q = {expected_q, r};
    endfunction

    task report(string msg);
      $display("tb: mismatch at %0t: %s", $time, msg);
      errors++;
    endtask

    task check_result(logic f, logic e, logic [KEY_W-1:0] ek, logic [COUNT_W-1:0] c);
      mru_result_t x;
      if (expected_q.size() == 0) begin
        report("result beat with nothing expected");
        return;
      end
      x = expected_q.pop_front();
      if (f !== x.found) report($sformatf("found %0b, want %0b", f, x.found));
      if (e !== x.evicted) report($sformatf("evicted %0b, want %0b", e, x.evicted));
      if (ek !== x.dropped) report($sformatf("evicted_key %h, want %h", ek, x.dropped));
      if (c !== x.count) report($sformatf("entry_count %0d, want %0d", c, x.count));
    endtask
  endclass

  logic               clk;
  logic               rst;
  logic               start;
  logic               busy;
  logic [OP_W-1:0]    operation;
  logic [KEY_W-1:0]   key;
  logic               cfg_we;
  logic [LIMIT_W-1:0] cfg_data;
  logic               done;
  logic               found;
  logic               evicted;
  logic [KEY_W-1:0]   evicted_key;
  logic [COUNT_W-1:0] entry_count;

  mru_scoreboard sb;
  int            cycles = 0;

  bounded_mru_list u_top (
    .clk         (clk),
    .rst         (rst),
    .start       (start),
    .busy        (busy),
    .operation   (operation),
    .key         (key),
    .cfg_we      (cfg_we),
    .cfg_data    (cfg_data),
    .done        (done),
    .found       (found),
    .evicted     (evicted),
    .evicted_key (evicted_key),
    .entry_count (entry_count)
  );

  always begin
    clk = 1'b0;
    #10;
    clk = 1'b1;
    #10;
  end

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles >= CYCLE_LIMIT) begin
      $display("tb: done, errors");
      $finish;
    end
  end

  // results are checked before the beat taken at the same edge is noted
  always @(posedge clk) begin
    if (!rst) begin
      if (done) sb.check_result(found, evicted, evicted_key, entry_count);
      if (start && !busy) sb.note_beat(mru_op_t'(operation), key);
    end
  end

  task automatic send(mru_op_t op, logic [KEY_W-1:0] k);
    start     <= 1'b1;
    operation <= op;
    key       <= k;
    do @(posedge clk); while (busy);
  endtask

  task automatic pause(int n);
    if (n > 0) begin
      start     <= 1'b0;
      operation <= OP_W'($urandom);
      key       <= {$urandom, $urandom};
      repeat (n) @(posedge clk);
    end
  endtask

  task automatic drain();
    start <= 1'b0;
    do @(posedge clk); while (sb.pending() != 0);
    repeat (2) @(posedge clk);
  endtask

  task automatic write_limit(logic [LIMIT_W-1:0] v);
    drain();
    cfg_we   <= 1'b1;
    cfg_data <= v;
    @(posedge clk);
    cfg_we   <= 1'b0;
    sb.limit = v;
  endtask

  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (r < 65) return 0;
    if (r < 92) return $urandom_range(1, 3);
    return $urandom_range(4, 30);
  endfunction

  task automatic run_phase(int n_items, int pool_n, bit no_gaps);
    logic [KEY_W-1:0] pool [32];
    logic [KEY_W-1:0] k;
    mru_op_t          op;
    int               r;
    for (int i = 0; i < pool_n; i++) pool[i] = {$urandom, $urandom};
    if ($urandom_range(0, 1)) pool[0] = '0;
    if ($urandom_range(0, 1)) pool[pool_n-1] = '1;
    for (int i = 0; i < n_items; i++) begin
      r  = $urandom_range(0, 99);
      op = (r < 60) ? OP_INSERT : (r < 95) ? OP_CHECK : (r < 98) ? OP_NOP : OP_CLEAR;
      k  = ($urandom_range(0, 9) < 8) ? pool[$urandom_range(0, pool_n - 1)]
                                       : {$urandom, $urandom};
      send(op, k);
      if (!no_gaps) pause(pick_gap());
      if ($urandom_range(0, 199) == 0) drain();
    end
  endtask

  int limits [10] = '{1, 16, 4, 0, 31, 17, 7, 2, 13, 10};

  initial begin
    sb = new();
    rst       <= 1'b1;
    start     <= 1'b0;
    operation <= OP_INSERT;
    key       <= '0;
    cfg_we    <= 1'b0;
    cfg_data  <= '0;
    repeat (7) @(posedge clk);
    rst <= 1'b0;

    // reset limit of 10: empty lookup, hits, tail move, filling to the limit
    send(OP_CHECK, '0);
    send(OP_INSERT, '0);
    send(OP_INSERT, '1);
    send(OP_INSERT, '0);
    send(OP_CHECK, '1);
    send(OP_CHECK, 64'h5);
    send(OP_NOP, '1);
    for (int i = 1; i <= 9; i++) send(OP_INSERT, KEY_W'(i));
    send(OP_INSERT, '0);
    pause(4);
    send(OP_CLEAR, 64'hAAAA_AAAA_AAAA_AAAA);
    send(OP_INSERT, 64'hAAAA_AAAA_AAAA_AAAA);
    send(OP_INSERT, 64'h5555_5555_5555_5555);
    send(OP_CHECK, 64'h5555_5555_5555_5555);

    for (int p = 0; p < 10; p++) begin
      // limit 4 follows a full list at 16 and is set without a clear
      if (limits[p] == 4) begin
        for (int i = 0; i < 16; i++) send(OP_INSERT, 64'hF00D_0000_0000_0000 | KEY_W'(i));
        write_limit(LIMIT_W'(limits[p]));
      end else begin
        write_limit(LIMIT_W'(limits[p]));
        send(OP_CLEAR, {$urandom, $urandom});
      end
      run_phase(200, $urandom_range(2, 28), $urandom_range(0, 3) == 0);
    end

    drain();
    if (sb.pending() != 0) sb.report("expected results left over");
    if (sb.errors == 0) begin
      $display("tb: done, clean");
    end else begin
      $display("tb: done, errors");
    end
    $finish;
  end

endmodule

/* files.f */
src/mru_pkg.sv
src/mru_cell.sv
src/bounded_mru_list.sv
src/mru_checker.sv
bench/tb.sv
